### src/ctgcb_pkg.sv
`default_nettype none
package ctgcb_pkg;

  localparam int PIXEL_BITS = 16;
  localparam int LOG_FRAC   = 16;
  localparam int MANT_W     = 31;
  localparam int T_W        = 22;
  localparam int GAIN_W     = 17;
  localparam int ALPHA_W    = 13;
  localparam int CFG_IDX_W  = 8;

  localparam logic [12:0] ALPHA_MAX = 13'd4096;

  // ceil(2^36 / 1000): floor(x / 1000) = (x * DIV_RECIP) >> 36 for x < 2^27
  localparam logic [26:0] DIV_RECIP = 27'd68719477;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GAIN  = 8'd0,
    CFG_ALPHA = 8'd1
  } cfg_idx_e;

  typedef struct packed {
    logic [PIXEL_BITS-1:0] y;
    logic                  cd_neg;
    logic [PIXEL_BITS-1:0] cdmag;
    logic [3:0]            msb;
  } side_t;

  function automatic logic [63:0] isqrt64(logic [63:0] v);
    logic [63:0] rem;
    logic [63:0] res;
    logic [63:0] bitv;
    rem  = v;
    res  = 64'd0;
    bitv = 64'd1 << 62;
    for (int k = 0; k < 32; k++) begin
      if (rem >= res + bitv) begin
        rem = rem - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  // 2^(-2^-idx) in Q1.30
  function automatic logic [MANT_W-1:0] root_const(int idx);
    logic [63:0] c;
    c = 64'd1 << 30;
    for (int k = 1; k <= LOG_FRAC; k++) begin
      if (k <= idx) begin
        if (k == 1) c = isqrt64(64'd1 << 59);
        else        c = isqrt64(c << 30);
      end
    end
    return c[MANT_W-1:0];
  endfunction

endpackage
`default_nettype wire

### src/ctgcb_log_stage.sv
`default_nettype none
module ctgcb_log_stage (
  input  wire logic                          clk_i,
  input  wire logic                          en_i,
  input  wire logic [ctgcb_pkg::MANT_W-1:0]  mant_i,
  input  wire logic [ctgcb_pkg::LOG_FRAC-1:0] frac_i,
  input  wire ctgcb_pkg::side_t              side_i,
  output logic [ctgcb_pkg::MANT_W-1:0]       mant_o,
  output logic [ctgcb_pkg::LOG_FRAC-1:0]     frac_o,
  output ctgcb_pkg::side_t                   side_o
);
  import ctgcb_pkg::*;

  logic [2*MANT_W-1:0] sq;
  logic [MANT_W:0]     y2;
  logic [MANT_W-1:0]   mant_d;
  logic [LOG_FRAC-1:0] frac_d;

  // square the mantissa; one fraction bit of the log per stage
  always_comb begin
    sq     = (2*MANT_W)'(mant_i) * (2*MANT_W)'(mant_i);
    y2     = sq[2*MANT_W-1:30];
    mant_d = y2[MANT_W] ? y2[MANT_W:1] : y2[MANT_W-1:0];
    frac_d = {frac_i[LOG_FRAC-2:0], y2[MANT_W]};
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mant_o <= mant_d;
      frac_o <= frac_d;
      side_o <= side_i;
    end
  end
endmodule
`default_nettype wire

### src/ctgcb_exp_stage.sv
`default_nettype none
module ctgcb_exp_stage #(
  parameter int IDX = 1
) (
  input  wire logic                         clk_i,
  input  wire logic                         en_i,
  input  wire logic [ctgcb_pkg::MANT_W-1:0] v_i,
  input  wire logic [ctgcb_pkg::T_W-1:0]    t_i,
  input  wire ctgcb_pkg::side_t             side_i,
  output logic [ctgcb_pkg::MANT_W-1:0]      v_o,
  output logic [ctgcb_pkg::T_W-1:0]         t_o,
  output ctgcb_pkg::side_t                  side_o
);
  import ctgcb_pkg::*;

  localparam int                BIT_POS = LOG_FRAC - IDX;
  localparam logic [MANT_W-1:0] ROOT_C  = root_const(IDX);

  logic [2*MANT_W-1:0] prod;
  logic [MANT_W-1:0]   v_d;

  // multiply by 2^(-2^-IDX) when that fraction bit of t is set, round half up
  always_comb begin
    prod = (2*MANT_W)'(v_i) * (2*MANT_W)'(ROOT_C) + ((2*MANT_W)'(1) << 29);
    v_d  = t_i[BIT_POS] ? prod[MANT_W+29:30] : v_i;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      v_o    <= v_d;
      t_o    <= t_i;
      side_o <= side_i;
    end
  end
endmodule
`default_nettype wire

### src/color_to_gray_chroma_boost_unit.sv
// Color to gray conversion with chroma-difference contrast boost.
// Input stream s_axis_*: one RGB pixel per item, three Q0.16 channels in tdata.
// Output stream m_axis_*: one Q0.16 gray value per item.
// cfg_*: register writes; index 0 is the signed Q4.12 contrast gain, index 1 the
// Q1.12 extra exponent (values above 1.0 act as 1.0). Write only while idle;
// cfg_ready_o is always high.
// Gray = Y + sign(Cd) * k * |Cd|^(1+alpha), clamped to [0, full scale], where
// the power goes through a 16-bit log2 by repeated squaring and an exp2 by a
// product of constant roots.
// The accepting edge loads the first of 39 pipeline stages (luma and chroma,
// divide by 1000, normalize, 16 squaring stages, exponent scale, 16
// root-multiply stages, shift, power, gain), and the item leaves the last
// stage into the output register.
// Throughput is one item per cycle while the skid register is empty.
// Reset clears all valid bits and loads gain 3.0 and alpha 0.5.
// When the receiver stalls, the output register holds its item and one more
// finished item goes into a skid register; only then does the pipeline
// freeze and s_axis_tready drop. Nothing is lost or repeated.
`default_nettype none
module color_to_gray_chroma_boost_unit (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            s_axis_tvalid,
  output logic                                 s_axis_tready,
  input  wire logic [47:0]                     s_axis_tdata,  // red_in, green_in, blue_in
  output logic                                 m_axis_tvalid,
  input  wire logic                            m_axis_tready,
  output logic [15:0]                          m_axis_tdata,  // gray_out
  input  wire logic                            cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  wire logic [ctgcb_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [ctgcb_pkg::GAIN_W-1:0]    cfg_data_i
);
  import ctgcb_pkg::*;

  localparam int NS = 39;
  localparam int PB = PIXEL_BITS;

  // configuration registers
  logic [GAIN_W-1:0]  gain_q;
  logic [ALPHA_W-1:0] alpha_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q  <= 17'd12288;
      alpha_q <= 13'd2048;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_GAIN:  gain_q  <= cfg_data_i;
        CFG_ALPHA: alpha_q <= cfg_data_i[ALPHA_W-1:0];
        default:   ;
      endcase
    end
  end

  logic [ALPHA_W-1:0] alpha_sat;
  logic               k_neg;
  logic [GAIN_W-1:0]  kmag;

  assign alpha_sat = (alpha_q > ALPHA_MAX) ? ALPHA_MAX : alpha_q;
  assign k_neg     = gain_q[GAIN_W-1];
  assign kmag      = k_neg ? (GAIN_W)'(~gain_q + 1'b1) : gain_q;

  // advance the whole pipeline unless the skid register is occupied
  logic          en;
  logic          skid_vld_q;
  logic [NS:1]   vld_q;

  assign en            = !skid_vld_q;
  assign s_axis_tready = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[NS-1:1], s_axis_tvalid};
    end
  end

  // stage 1: luma and chroma difference in thousandths
  logic [PB-1:0] r_in, g_in, b_in;
  logic [26:0]   cpos, cneg;
  logic [25:0]   ynum_d;
  logic [26:0]   cdabs_d;
  logic [25:0]   ynum_q;
  logic [26:0]   cdabs_q;
  logic          cdneg1_q;

  assign r_in = s_axis_tdata[15:0];
  assign g_in = s_axis_tdata[31:16];
  assign b_in = s_axis_tdata[47:32];

  always_comb begin
    ynum_d  = 26'(r_in) * 26'd299 + 26'(g_in) * 26'd587 + 26'(b_in) * 26'd114 + 26'd500;
    cpos    = 27'(r_in) * 27'd669;
    cneg    = 27'(g_in) * 27'd88 + 27'(b_in) * 27'd581;
    cdabs_d = (cpos < cneg) ? (cneg - cpos) : (cpos - cneg);
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      ynum_q   <= ynum_d;
      cdabs_q  <= cdabs_d;
      cdneg1_q <= (cpos < cneg);
    end
  end

  // stage 2: divide by 1000 through the reciprocal
  logic [53:0]   yprod, cprod;
  logic [PB-1:0] y2_q, cdmag2_q;
  logic          cdneg2_q;

  assign yprod = 54'(ynum_q) * 54'(DIV_RECIP);
  assign cprod = 54'(cdabs_q + 27'd500) * 54'(DIV_RECIP);

  always_ff @(posedge clk_i) begin
    if (en) begin
      y2_q     <= yprod[51:36];
      cdmag2_q <= cprod[51:36];
      cdneg2_q <= cdneg1_q;
    end
  end

  // stage 3: find the leading one and normalize to Q1.30
  logic [3:0]        msb_d;
  logic [MANT_W-1:0] mant_ext;
  logic [MANT_W-1:0] mant3_q;
  side_t             side3_q;

  always_comb begin
    msb_d = 4'd0;
    for (int i = 0; i < PB; i++) begin
      if (cdmag2_q[i]) msb_d = 4'(i);
    end
    mant_ext = (MANT_W)'(cdmag2_q);
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      mant3_q       <= mant_ext << (5'd30 - 5'(msb_d));
      side3_q.y      <= y2_q;
      side3_q.cd_neg <= cdneg2_q;
      side3_q.cdmag  <= cdmag2_q;
      side3_q.msb    <= msb_d;
    end
  end

  // stages 4..19: log2 fraction bits
  logic [MANT_W-1:0]   lmant [0:LOG_FRAC];
  logic [LOG_FRAC-1:0] lfrac [0:LOG_FRAC];
  side_t               lside [0:LOG_FRAC];

  assign lmant[0] = mant3_q;
  assign lfrac[0] = '0;
  assign lside[0] = side3_q;

  for (genvar gi = 1; gi <= LOG_FRAC; gi++) begin : g_log
    ctgcb_log_stage u_log (
      .clk_i  (clk_i),
      .en_i   (en),
      .mant_i (lmant[gi-1]),
      .frac_i (lfrac[gi-1]),
      .side_i (lside[gi-1]),
      .mant_o (lmant[gi]),
      .frac_o (lfrac[gi]),
      .side_o (lside[gi])
    );
  end

  // stage 20: t = alpha * (-log2|Cd|), rounded to Q.16
  logic [4:0]     lint;
  logic [20:0]    lval;
  logic [33:0]    tprod;
  logic [T_W-1:0] t4_q;
  side_t          side4_q;

  always_comb begin
    lint  = 5'd16 - 5'(lside[LOG_FRAC].msb);
    lval  = {lint, 16'b0} - 21'(lfrac[LOG_FRAC]);
    tprod = 34'(alpha_sat) * 34'(lval) + 34'd2048;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      t4_q    <= tprod[33:12];
      side4_q <= lside[LOG_FRAC];
    end
  end

  // stages 21..36: 2^-frac(t) as a product of roots
  logic [MANT_W-1:0] ev [0:LOG_FRAC];
  logic [T_W-1:0]    et [0:LOG_FRAC];
  side_t             es [0:LOG_FRAC];

  assign ev[0] = (MANT_W)'(1) << 30;
  assign et[0] = t4_q;
  assign es[0] = side4_q;

  for (genvar gi = 1; gi <= LOG_FRAC; gi++) begin : g_exp
    ctgcb_exp_stage #(.IDX(gi)) u_exp (
      .clk_i  (clk_i),
      .en_i   (en),
      .v_i    (ev[gi-1]),
      .t_i    (et[gi-1]),
      .side_i (es[gi-1]),
      .v_o    (ev[gi]),
      .t_o    (et[gi]),
      .side_o (es[gi])
    );
  end

  // stage 37: shift by the integer part of t
  logic [MANT_W-1:0] vs_q;
  side_t             side5_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      vs_q    <= ev[LOG_FRAC] >> et[LOG_FRAC][T_W-1:LOG_FRAC];
      side5_q <= es[LOG_FRAC];
    end
  end

  // stage 38: |Cd|^(1+alpha)
  logic [46:0]   pprod;
  logic [PB-1:0] pw_q;
  logic [PB-1:0] y6_q;
  logic          bneg6_q;

  assign pprod = 47'(side5_q.cdmag) * 47'(vs_q) + (47'd1 << 29);

  always_ff @(posedge clk_i) begin
    if (en) begin
      pw_q    <= pprod[45:30];
      y6_q    <= side5_q.y;
      bneg6_q <= k_neg ^ side5_q.cd_neg;
    end
  end

  // stage 39: scale by the gain magnitude
  logic [33:0]   bprod;
  logic [21:0]   boost_q;
  logic [PB-1:0] y7_q;
  logic          bneg7_q;

  assign bprod = 34'(kmag) * 34'(pw_q) + 34'd2048;

  always_ff @(posedge clk_i) begin
    if (en) begin
      boost_q <= bprod[33:12];
      y7_q    <= y6_q;
      bneg7_q <= bneg6_q;
    end
  end

  // add or subtract the boost and clamp to full scale
  logic [22:0]   sum_up;
  logic [PB-1:0] gray_d;

  always_comb begin
    sum_up = 23'(y7_q) + 23'(boost_q);
    if (bneg7_q) begin
      gray_d = (22'(y7_q) < boost_q) ? '0 : PB'(22'(y7_q) - boost_q);
    end else begin
      gray_d = (sum_up > 23'(16'hFFFF)) ? 16'hFFFF : sum_up[PB-1:0];
    end
  end

  // output register with skid stage
  logic          out_vld_q, out_vld_d;
  logic          skid_vld_d;
  logic [PB-1:0] out_q, out_d;
  logic [PB-1:0] skid_q, skid_d;
  logic          push, pop;

  assign push = en && vld_q[NS];
  assign pop  = out_vld_q && m_axis_tready;

  always_comb begin
    out_vld_d  = out_vld_q;
    skid_vld_d = skid_vld_q;
    out_d      = out_q;
    skid_d     = skid_q;
    if (pop) begin
      if (skid_vld_q) begin
        out_d      = skid_q;
        skid_vld_d = 1'b0;
      end else begin
        out_vld_d = 1'b0;
      end
    end
    if (push) begin
      if (!out_vld_d) begin
        out_d     = gray_d;
        out_vld_d = 1'b1;
      end else begin
        skid_d     = gray_d;
        skid_vld_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else begin
      out_vld_q  <= out_vld_d;
      skid_vld_q <= skid_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_q;

endmodule
`default_nettype wire
